// ===== rtl/tmsc_pkg.sv =====
// shared types and constants of the timer mult/shift calculator
package tmsc_pkg;

  localparam int unsigned CountW   = 64;
  localparam int unsigned FreqW    = 32;
  localparam int unsigned MultW    = 32;
  localparam int unsigned ShiftW   = 6;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned ProdW    = 62;
  localparam int unsigned TlenW    = ProdW - 32;
  localparam int unsigned DivCntW  = 7;
  localparam int unsigned InDataW  = 160;
  localparam int unsigned OutDataW = 168;

  localparam logic [CountW-1:0]  NsPerSecond = 64'd1000000000;
  localparam logic [CountW-1:0]  HalfSecond  = NsPerSecond / 2;
  localparam logic [CountW-1:0]  SecsCap     = 64'd600;
  localparam logic [CountW-1:0]  NsFloor     = 64'd1000;
  localparam logic [ShiftW-1:0]  MaxShift    = 6'd32;
  localparam logic [DivCntW-1:0] DivSteps    = 7'd64;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_SKIP   = 2'd1,
    STATUS_NOFREQ = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SECS,
    ST_MUL,
    ST_LEN,
    ST_SDIV,
    ST_CSH,
    ST_CDIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic              start;
    logic [CountW-1:0] dividend;
    logic [MultW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [CountW-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/tmsc_div.sv =====
// radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle
module tmsc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tmsc_pkg::div_req_t req_i,
  output tmsc_pkg::div_rsp_t rsp_o
);
  import tmsc_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [MultW-1:0]   rem_q;
  logic [CountW-1:0]  quot_q;
  logic [MultW-1:0]   dvsr_q;
  logic [MultW:0]     rem_sh;
  logic [MultW:0]     diff;
  logic               ge;

  assign rem_sh = {rem_q, quot_q[CountW-1]};
  assign ge     = rem_sh >= {1'b0, dvsr_q};
  assign diff   = rem_sh - {1'b0, dvsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DivSteps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == 7'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quot_q <= req_i.dividend;
      dvsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[MultW-1:0] : rem_sh[MultW-1:0];
      quot_q <= {quot_q[CountW-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== rtl/timer_mult_shift_calculator.sv =====
// top level of the timer mult/shift calculator
//
// channel  dir  tdata (low bit up)                                tuser
// s_axis   in   frequency_hz, min_count, max_count                 oneshot
// m_axis   out  mult_out, shift_out, min_nanoseconds,              status
//               max_nanoseconds, 2 zero bits
//
// one word at a time; a periodic or zero-frequency word goes to the finish state, then idle
// a computed word runs seconds division, multiply, length count, one division per tried shift
// and a shift and division for each of min and max, on the shared one-bit-per-cycle divider
// the next word is taken while the result waits in the output register
// reset clears the control state only, there is no clearing pass
module timer_mult_shift_calculator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [tmsc_pkg::InDataW-1:0]      s_axis_tdata_i,  // frequency_hz, min_count, max_count
  input  logic                              s_axis_tuser_i,  // oneshot
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [tmsc_pkg::OutDataW-1:0]     m_axis_tdata_o,  // mult_out, shift_out, min_ns, max_ns
  output logic [tmsc_pkg::StatusW-1:0]      m_axis_tuser_o   // status
);
  import tmsc_pkg::*;

  state_e              state_q, state_d;
  status_e             status_q, status_d;
  logic [FreqW-1:0]    freq_q, freq_d;
  logic [CountW-1:0]   minc_q, minc_d;
  logic [CountW-1:0]   maxc_q, maxc_d;
  logic [FreqW-1:0]    secs_q, secs_d;
  logic [ProdW-1:0]    prod_q, prod_d;
  logic [TlenW-1:0]    tlen_q, tlen_d;
  logic [ShiftW-1:0]   acc_q, acc_d;
  logic [ShiftW-1:0]   cnt_q, cnt_d;
  logic [CountW-1:0]   fsh_q, fsh_d;
  logic [ShiftW-1:0]   sft_q, sft_d;
  logic [MultW-1:0]    mult_q, mult_d;
  logic [CountW-1:0]   sh_q, sh_d;
  logic                ovf_q, ovf_d;
  logic                upper_q, upper_d;
  logic [CountW-1:0]   min_ns_q, min_ns_d;
  logic [CountW-1:0]   max_ns_q, max_ns_d;
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  status_e             out_user_q, out_user_d;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic [CountW-1:0]   q;
  logic [CountW-1:0]   hi_mask;
  logic                fits;
  logic [CountW-1:0]   sh_eff;
  logic [CountW-1:0]   add;
  logic                mult_le;
  logic [CountW-1:0]   res_ns;
  logic [FreqW-1:0]    in_freq;
  logic                accept;

  tmsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign q       = div_rsp.quot;
  assign hi_mask = ~64'd0 << acc_q;
  assign fits    = (q & hi_mask) == '0;
  assign sh_eff  = ovf_q ? ~64'd0 : sh_q;
  assign add     = {32'd0, mult_q - 32'd1};
  assign mult_le = {1'b0, mult_q} <= (33'd1 << sft_q);
  assign res_ns  = (q > NsFloor) ? q : NsFloor;
  assign in_freq = s_axis_tdata_i[FreqW-1:0];
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    freq_d      = freq_q;
    minc_d      = minc_q;
    maxc_d      = maxc_q;
    secs_d      = secs_q;
    prod_d      = prod_q;
    tlen_d      = tlen_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    fsh_d       = fsh_q;
    sft_d       = sft_q;
    mult_d      = mult_q;
    sh_d        = sh_q;
    ovf_d       = ovf_q;
    upper_d     = upper_q;
    min_ns_d    = min_ns_q;
    max_ns_d    = max_ns_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    div_req     = '{start: 1'b0, dividend: maxc_q, divisor: freq_q};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          freq_d   = in_freq;
          minc_d   = s_axis_tdata_i[FreqW+CountW-1:FreqW];
          maxc_d   = s_axis_tdata_i[FreqW+2*CountW-1:FreqW+CountW];
          mult_d   = '0;
          sft_d    = '0;
          min_ns_d = '0;
          max_ns_d = '0;
          priority if (!s_axis_tuser_i) begin
            status_d = STATUS_SKIP;
            state_d  = ST_FIN;
          end else if (in_freq == '0) begin
            status_d = STATUS_NOFREQ;
            state_d  = ST_FIN;
          end else begin
            status_d         = STATUS_OK;
            div_req.start    = 1'b1;
            div_req.dividend = s_axis_tdata_i[FreqW+2*CountW-1:FreqW+CountW];
            div_req.divisor  = in_freq;
            state_d          = ST_SECS;
          end
        end
      end
      ST_SECS: begin
        if (div_rsp.done) begin
          priority if (q == '0) begin
            secs_d = 32'd1;
          end else if (q > SecsCap && maxc_q[CountW-1:32] != '0) begin
            secs_d = SecsCap[FreqW-1:0];
          end else begin
            secs_d = q[FreqW-1:0];
          end
          prod_d  = '0;
          cnt_d   = MaxShift;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_q != '0) begin
          prod_d = {prod_q[ProdW-2:0], 1'b0}
                 + (secs_q[FreqW-1] ? NsPerSecond[ProdW-1:0] : '0);
          secs_d = {secs_q[FreqW-2:0], 1'b0};
          cnt_d  = cnt_q - 1'b1;
        end else begin
          tlen_d  = prod_q[ProdW-1:32];
          acc_d   = MaxShift;
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        if (tlen_q != '0 && acc_q != '0) begin
          tlen_d = tlen_q >> 1;
          acc_d  = acc_q - 1'b1;
        end else begin
          sft_d            = MaxShift;
          fsh_d            = {freq_q, 32'd0};
          div_req.start    = 1'b1;
          div_req.dividend = {freq_q, 32'd0} + HalfSecond;
          div_req.divisor  = NsPerSecond[MultW-1:0];
          state_d          = ST_SDIV;
        end
      end
      ST_SDIV: begin
        div_req.divisor = NsPerSecond[MultW-1:0];
        if (div_rsp.done) begin
          if (fits || sft_q == 6'd1) begin
            mult_d  = (q[MultW-1:0] == '0) ? 32'd1 : q[MultW-1:0];
            sft_d   = fits ? sft_q : '0;
            cnt_d   = fits ? sft_q : '0;
            sh_d    = minc_q;
            ovf_d   = 1'b0;
            upper_d = 1'b0;
            state_d = ST_CSH;
          end else begin
            sft_d            = sft_q - 1'b1;
            fsh_d            = fsh_q >> 1;
            div_req.start    = 1'b1;
            div_req.dividend = (fsh_q >> 1) + HalfSecond;
          end
        end
      end
      ST_CSH: begin
        div_req.divisor = mult_q;
        if (cnt_q != '0) begin
          ovf_d = ovf_q | sh_q[CountW-1];
          sh_d  = {sh_q[CountW-2:0], 1'b0};
          cnt_d = cnt_q - 1'b1;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = ((~sh_eff > add) && (!upper_q || mult_le)) ? sh_eff + add
                                                                        : sh_eff;
          state_d          = ST_CDIV;
        end
      end
      ST_CDIV: begin
        div_req.divisor = mult_q;
        if (div_rsp.done) begin
          if (!upper_q) begin
            min_ns_d = res_ns;
            upper_d  = 1'b1;
            sh_d     = maxc_q;
            cnt_d    = sft_q;
            ovf_d    = 1'b0;
            state_d  = ST_CSH;
          end else begin
            max_ns_d = res_ns;
            state_d  = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {2'b00, max_ns_q, min_ns_q, sft_q, mult_q};
          out_user_d  = status_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    freq_q     <= freq_d;
    minc_q     <= minc_d;
    maxc_q     <= maxc_d;
    secs_q     <= secs_d;
    prod_q     <= prod_d;
    tlen_q     <= tlen_d;
    acc_q      <= acc_d;
    cnt_q      <= cnt_d;
    fsh_q      <= fsh_d;
    sft_q      <= sft_d;
    mult_q     <= mult_d;
    sh_q       <= sh_d;
    ovf_q      <= ovf_d;
    upper_q    <= upper_d;
    min_ns_q   <= min_ns_d;
    max_ns_q   <= max_ns_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef NO_ASSERTIONS
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != STATUS_OK) |-> m_axis_tdata_o == '0)
    else $error("skipped word carries nonzero fields");

  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == STATUS_OK) |->
      (m_axis_tdata_o[31:0] != '0 && m_axis_tdata_o[37:32] <= MaxShift &&
       m_axis_tdata_o[101:38] >= NsFloor && m_axis_tdata_o[165:102] >= NsFloor))
    else $error("computed word out of range");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
`endif

endmodule
